/* src/tida_pkg.sv */
// Shared constants, types and codes for the transaction ID allocator.
package tida_pkg;

  localparam int ID_COUNT = 256;
  localparam int ID_W     = $clog2(ID_COUNT);
  localparam int CNT_W    = $clog2(ID_COUNT + 1);
  localparam int KEY_W    = 16;
  localparam int IP_W     = 32;
  localparam int PORT_W   = 16;
  localparam int BIND_W   = KEY_W + IP_W + PORT_W;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_UNUSED  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

/* src/tida_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tida_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tida_ctrl.sv */
// Controller state machine that sequences one request through read and execute.
module tida_ctrl import tida_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output ctrl_cmd_t ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctrl.exec;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    busy       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        ctrl.exec  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/tida_dp.sv */
// Datapath: free ring, in-use bits, binding store and result registers.
module tida_dp import tida_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         ctrl,
  input  logic              cmd,
  input  logic [KEY_W-1:0]  key_id,
  input  logic [IP_W-1:0]   client_ip,
  input  logic [PORT_W-1:0] client_port,
  output logic [1:0]        status,
  output logic [ID_W-1:0]   mapped_id,
  output logic [KEY_W-1:0]  orig_query_id,
  output logic [IP_W-1:0]   saved_ip,
  output logic [PORT_W-1:0] saved_port
);

  logic              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [IP_W-1:0]   ip_q;
  logic [PORT_W-1:0] port_q;

  logic [ID_W-1:0]     ring_head;
  logic [ID_W-1:0]     ring_tail;
  logic [CNT_W-1:0]    free_count;
  logic                ring_wrapped;
  logic [ID_COUNT-1:0] in_use;

  status_t           status_q;
  logic [ID_W-1:0]   mapped_q;
  logic [KEY_W-1:0]  query_q;
  logic [IP_W-1:0]   sip_q;
  logic [PORT_W-1:0] sport_q;

  logic [ID_W-1:0]   ring_rdata;
  logic [BIND_W-1:0] bind_rdata;
  logic              ring_we;
  logic              bind_we;
  logic [ID_W-1:0]   alloc_id;
  logic              ring_filled;
  logic              list_empty;
  logic              key_in_range;
  logic              key_used;
  logic              ring_not_full;
  logic [ID_W-1:0]   head_inc;
  logic [ID_W-1:0]   tail_inc;

  // Ring entries that were never written are taken to hold their own index.
  assign ring_filled   = ring_wrapped || (ring_head < ring_tail);
  assign alloc_id      = ring_filled ? ring_rdata : ring_head;
  assign list_empty    = (free_count == '0);
  assign key_in_range  = ({1'b0, key_q} < (KEY_W + 1)'(ID_COUNT));
  assign key_used      = key_in_range && in_use[key_q[ID_W-1:0]];
  assign ring_not_full = (free_count < CNT_W'(ID_COUNT));
  assign head_inc      = (ring_head == ID_W'(ID_COUNT - 1)) ? '0 : ring_head + 1'b1;
  assign tail_inc      = (ring_tail == ID_W'(ID_COUNT - 1)) ? '0 : ring_tail + 1'b1;

  assign bind_we = ctrl.exec && (cmd_q == CMD_ALLOC) && !list_empty;
  assign ring_we = ctrl.exec && (cmd_q == CMD_RELEASE) && key_used && ring_not_full;

  tida_ram #(
    .WIDTH(ID_W),
    .DEPTH(ID_COUNT)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ring_tail),
    .wdata(key_q[ID_W-1:0]),
    .raddr(ring_head),
    .rdata(ring_rdata)
  );

  tida_ram #(
    .WIDTH(BIND_W),
    .DEPTH(ID_COUNT)
  ) u_bind (
    .clk  (clk),
    .we   (bind_we),
    .waddr(alloc_id),
    .wdata({key_q, ip_q, port_q}),
    .raddr(key_id[ID_W-1:0]),
    .rdata(bind_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= cmd;
      key_q  <= key_id;
      ip_q   <= client_ip;
      port_q <= client_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head    <= '0;
      ring_tail    <= '0;
      free_count   <= CNT_W'(ID_COUNT);
      ring_wrapped <= 1'b0;
      in_use       <= '0;
    end else if (ctrl.exec) begin
      if (cmd_q == CMD_ALLOC) begin
        if (!list_empty) begin
          ring_head        <= head_inc;
          free_count       <= free_count - 1'b1;
          in_use[alloc_id] <= 1'b1;
        end
      end else if (key_used) begin
        in_use[key_q[ID_W-1:0]] <= 1'b0;
        if (ring_not_full) begin
          ring_tail  <= tail_inc;
          free_count <= free_count + 1'b1;
          if (tail_inc == '0) begin
            ring_wrapped <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      query_q <= '0;
      sip_q   <= '0;
      sport_q <= '0;
      if (cmd_q == CMD_ALLOC) begin
        if (list_empty) begin
          status_q <= ST_NO_FREE;
          mapped_q <= '0;
        end else begin
          status_q <= ST_OK;
          mapped_q <= alloc_id;
        end
      end else begin
        mapped_q <= key_q[ID_W-1:0];
        if (key_used) begin
          status_q <= ST_OK;
          query_q  <= bind_rdata[BIND_W-1 -: KEY_W];
          sip_q    <= bind_rdata[PORT_W +: IP_W];
          sport_q  <= bind_rdata[PORT_W-1:0];
        end else begin
          status_q <= ST_UNUSED;
        end
      end
    end
  end

  assign status        = status_q;
  assign mapped_id     = mapped_q;
  assign orig_query_id = query_q;
  assign saved_ip      = sip_q;
  assign saved_port    = sport_q;

endmodule

/* src/transaction_id_allocator_unit.sv */
// Top level of the transaction ID allocator: controller plus datapath.
//
//   Channel   Handshake           Fields
//   request   start / busy        cmd, key_id, client_ip, client_port
//   result    done (one cycle)    status, mapped_id, orig_query_id, saved_ip, saved_port
//
// A request is taken when start is high and busy is low; busy is then high for one cycle
// while the free ring and binding store, read at the accept edge, are updated.
// The result appears with done in the next cycle, when a new request may already be taken;
// no new request is taken while busy is high, as the registered memory read comes first.
// Reset is synchronous and makes all IDs free in ascending order with no pass over memory.
// The receiver cannot stall; every result is shown for exactly one cycle.
module transaction_id_allocator_unit import tida_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cmd,
  input  logic [KEY_W-1:0]  key_id,
  input  logic [IP_W-1:0]   client_ip,
  input  logic [PORT_W-1:0] client_port,
  output logic              done,
  output logic [1:0]        status,
  output logic [ID_W-1:0]   mapped_id,
  output logic [KEY_W-1:0]  orig_query_id,
  output logic [IP_W-1:0]   saved_ip,
  output logic [PORT_W-1:0] saved_port
);

  ctrl_cmd_t ctrl;

  tida_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .ctrl (ctrl)
  );

  tida_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cmd          (cmd),
    .key_id       (key_id),
    .client_ip    (client_ip),
    .client_port  (client_port),
    .status       (status),
    .mapped_id    (mapped_id),
    .orig_query_id(orig_query_id),
    .saved_ip     (saved_ip),
    .saved_port   (saved_port)
  );

endmodule

/* src/tida_checker.sv */
// Port-level checks for the transaction ID allocator, bound to the top level.
module tida_checker import tida_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [1:0]        status,
  input logic [ID_W-1:0]   mapped_id,
  input logic [KEY_W-1:0]  orig_query_id,
  input logic [IP_W-1:0]   saved_ip,
  input logic [PORT_W-1:0] saved_port
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("busy request did not finish with done in one cycle");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a request in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NO_FREE || status == ST_UNUSED))
    else $error("result status code out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |->
      (mapped_id == mapped_id && orig_query_id == '0 && saved_ip == '0 &&
       saved_port == '0))
    else $error("error result carries binding data");

endmodule

bind transaction_id_allocator_unit tida_checker u_tida_checker (.*);
